// ===== hw/rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int QIDX_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int ID_W      = 4;
  localparam int MODE_W    = 3;
  localparam int SLICE_W   = 16;
  localparam int LOCK_W    = 8;
  localparam int COUNT_W   = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [LOCK_W-1:0]  LOCK_TOP    = '1;
  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);

  // register word indexes
  localparam logic REG_TIME_SLICE = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 3'd0,
    MODE_BLOCK     = 3'd1,
    MODE_UNBLOCK   = 3'd2,
    MODE_SCHED_LK  = 3'd3,
    MODE_SCHED_UNL = 3'd4,
    MODE_SW_LK     = 3'd5,
    MODE_SW_UNL    = 3'd6,
    MODE_YIELD     = 3'd7
  } mode_t;

  // broadcast to every cell of the ready queue
  typedef struct packed {
    logic            shift;
    logic [ID_W-1:0] wr_id;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/rrts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_cell
// One slot of the ready queue: holds an id, takes its neighbour's id on a
// shift and the broadcast id when selected for a write.
// ----------------------------------------------------------------------------
module rrts_cell
  import rrts_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             load,
  input  logic [ID_W-1:0]  right_id,
  output logic [ID_W-1:0]  id
);

  always_ff @(posedge clk) begin
    if (load) begin
      id <= ctrl.wr_id;
    end else if (ctrl.shift) begin
      id <= right_id;
    end
  end

endmodule

// ===== hw/rtl/rrts_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_regs
// APB register file holding the time slice length.
// ----------------------------------------------------------------------------
module rrts_regs
  import rrts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output logic [SLICE_W-1:0] time_slice
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice <= SLICE_RESET;
    end else if (wr_en && paddr[APB_AW-1] == REG_TIME_SLICE) begin
      time_slice <= pwdata[SLICE_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[APB_AW-1])
      REG_TIME_SLICE: prdata = APB_DW'(time_slice);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin time-slice scheduler with a shifting ready queue.
// ----------------------------------------------------------------------------
// Each accepted item is one scheduler event (tick, block, unblock, scheduler
// or switch lock and unlock, yield) and produces exactly one result in the cycle
// after, held in an output register until taken. A new item is accepted in
// every cycle while the result register is empty or being emptied, so the
// block runs at one item per clock; the ready queue is a row of cells that
// all shift toward the head on a dequeue, with the tail write landing in the
// same cycle, which is what keeps the update to a single step. The time
// slice register sits at byte address 0 of the APB port and is loaded into
// the tick counter on every task switch. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler
  import rrts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  mode,
  input  logic [ID_W-1:0]    task_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               switched,
  output logic [ID_W-1:0]    from_task,
  output logic [ID_W-1:0]    to_task,
  output logic               deferred,
  output logic [COUNT_W-1:0] ready_count,
  output logic               overflow
);

  logic [SLICE_W-1:0] time_slice;

  logic [CNT_W-1:0]   count;
  logic [ID_W-1:0]    cur_id;
  logic               cur_run;
  logic [SLICE_W-1:0] ticks;
  logic [LOCK_W-1:0]  sched_hold;
  logic [LOCK_W-1:0]  sw_lock;
  logic               pending;

  logic [CNT_W-1:0]   count_next;
  logic [ID_W-1:0]    cur_id_next;
  logic               cur_run_next;
  logic [SLICE_W-1:0] ticks_next;
  logic [LOCK_W-1:0]  sched_hold_next;
  logic [LOCK_W-1:0]  sw_lock_next;
  logic               pending_next;

  logic               sw_c;
  logic [ID_W-1:0]    from_c;
  logic               def_c;
  logic               ovf_c;
  logic               yield_req;
  logic               wr_en;
  logic [QIDX_W-1:0]  wr_pos;
  logic               accept;

  cell_ctrl_t         ctrl;
  logic [ID_W-1:0]    cell_id [MAX_TASKS];
  logic [MAX_TASKS-1:0] cell_load;

  rrts_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .time_slice (time_slice)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    count_next      = count;
    cur_id_next     = cur_id;
    cur_run_next    = cur_run;
    ticks_next      = ticks;
    sched_hold_next = sched_hold;
    sw_lock_next    = sw_lock;
    pending_next    = pending;
    sw_c            = 1'b0;
    from_c          = '0;
    def_c           = 1'b0;
    ovf_c           = 1'b0;
    yield_req       = 1'b0;
    wr_en           = 1'b0;
    wr_pos          = count[QIDX_W-1:0];
    ctrl.shift      = 1'b0;
    ctrl.wr_id      = cur_id;

    unique case (mode_t'(mode))
      MODE_TICK: begin
        if (ticks != '0) begin
          ticks_next = ticks - SLICE_W'(1);
        end
        yield_req = (sched_hold == '0) && (ticks_next == '0);
      end
      MODE_BLOCK: begin
        cur_run_next = 1'b0;
        yield_req    = 1'b1;
      end
      MODE_UNBLOCK: begin
        if (count == CNT_W'(MAX_TASKS)) begin
          ovf_c = 1'b1;
        end else begin
          wr_en      = 1'b1;
          ctrl.wr_id = task_id;
          count_next = count + CNT_W'(1);
          if (task_id == cur_id) begin
            cur_run_next = 1'b0;
          end
        end
      end
      MODE_SCHED_LK: begin
        if (sched_hold != LOCK_TOP) begin
          sched_hold_next = sched_hold + LOCK_W'(1);
        end
      end
      MODE_SCHED_UNL: begin
        if (sched_hold != '0) begin
          sched_hold_next = sched_hold - LOCK_W'(1);
        end
      end
      MODE_SW_LK: begin
        if (sw_lock != LOCK_TOP) begin
          sw_lock_next = sw_lock + LOCK_W'(1);
        end
      end
      MODE_SW_UNL: begin
        if (sw_lock != '0) begin
          sw_lock_next = sw_lock - LOCK_W'(1);
          // last unlock replays a postponed switch
          if (sw_lock == LOCK_W'(1) && pending) begin
            pending_next = 1'b0;
            yield_req    = 1'b1;
          end
        end
      end
      MODE_YIELD: begin
        yield_req = 1'b1;
      end
    endcase

    if (yield_req) begin
      if (sw_lock_next != '0) begin
        pending_next = 1'b1;
        def_c        = 1'b1;
      end else if (count != '0) begin
        // head leaves, a running task goes to the slot freed at the tail
        ctrl.shift = 1'b1;
        if (cur_run_next) begin
          wr_en      = 1'b1;
          wr_pos     = QIDX_W'(count - CNT_W'(1));
          ctrl.wr_id = cur_id;
        end else begin
          count_next = count - CNT_W'(1);
        end
        sw_c         = 1'b1;
        from_c       = cur_id;
        cur_id_next  = cell_id[0];
        cur_run_next = 1'b1;
        ticks_next   = time_slice;
      end
    end

    if (!accept) begin
      ctrl.shift = 1'b0;
      wr_en      = 1'b0;
    end
  end

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic [ID_W-1:0] right_id;

    if (i == MAX_TASKS - 1) begin : g_last
      assign right_id = cell_id[i];
    end else begin : g_mid
      assign right_id = cell_id[i+1];
    end

    assign cell_load[i] = wr_en && (wr_pos == QIDX_W'(i));

    rrts_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load     (cell_load[i]),
      .right_id (right_id),
      .id       (cell_id[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cur_id     <= '0;
      cur_run    <= 1'b1;
      ticks      <= '0;
      sched_hold <= '0;
      sw_lock    <= '0;
      pending    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        count      <= count_next;
        cur_id     <= cur_id_next;
        cur_run    <= cur_run_next;
        ticks      <= ticks_next;
        sched_hold <= sched_hold_next;
        sw_lock    <= sw_lock_next;
        pending    <= pending_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      switched    <= sw_c;
      from_task   <= from_c;
      to_task     <= cur_id_next;
      deferred    <= def_c;
      ready_count <= COUNT_W'(count_next);
      overflow    <= ovf_c;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("ready queue count beyond capacity");

  a_pending_locked: assert property (@(posedge clk) disable iff (rst)
    pending |-> sw_lock != '0)
    else $error("switch postponed with switches unlocked");

  a_switch_not_deferred: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(switched && deferred))
    else $error("item both switched and deferred");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> ready_count == COUNT_W'(MAX_TASKS))
    else $error("overflow reported with room in the queue");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

endmodule

// ===== tb/sv/round_robin_task_scheduler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_test
// Self-checking bench for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
// Scheduler events go in over a valid/ready channel and every one of them
// brings back one switch report. A scoreboard model inside the bench keeps
// its own ready queue, current task, slice counter and lock counts, works out
// the report for each accepted item and compares it with what comes out. The
// slice register is reprogrammed over APB between phases and read back.
// Directed cases come first, then slice extremes, queue overflow, lock
// saturation and a long random mix, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_test;
  import rrts_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [APB_AW-1:0] SLICE_ADDR = APB_AW'(REG_TIME_SLICE) << 2;

  typedef struct packed {
    logic               switched;
    logic [ID_W-1:0]    from_task;
    logic [ID_W-1:0]    to_task;
    logic               deferred;
    logic [COUNT_W-1:0] ready_count;
    logic               overflow;
  } sched_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [APB_AW-1:0]  paddr   = '0;
  logic [APB_DW-1:0]  pwdata  = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode     = MODE_TICK;
  logic [ID_W-1:0]    task_id  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               switched;
  logic [ID_W-1:0]    from_task;
  logic [ID_W-1:0]    to_task;
  logic               deferred;
  logic [COUNT_W-1:0] ready_count;
  logic               overflow;

  round_robin_task_scheduler dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .task_id    (task_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .switched   (switched),
    .from_task  (from_task),
    .to_task    (to_task),
    .deferred   (deferred),
    .ready_count(ready_count),
    .overflow   (overflow)
  );

  // scoreboard copy of the scheduler state
  logic [ID_W-1:0]    ready_ids [MAX_TASKS];
  logic [QIDX_W-1:0]  q_head       = '0;
  logic [COUNT_W-1:0] q_count      = '0;
  logic [ID_W-1:0]    cur_id       = '0;
  logic               cur_running  = 1'b1;
  logic [SLICE_W-1:0] slice_cfg    = SLICE_RESET;
  logic [SLICE_W-1:0] ticks_left   = '0;
  logic [LOCK_W-1:0]  sched_holds  = '0;
  logic [LOCK_W-1:0]  sw_locks     = '0;
  logic               sw_pending   = 1'b0;

  sched_report_t sched_reports[$];
  int            mismatches   = 0;
  int            reports_seen = 0;
  int            stall_left   = 0;
  bit            steady       = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic push_ready(input logic [ID_W-1:0] id);
    if (q_count >= COUNT_W'(MAX_TASKS))
      return 1'b0;
    ready_ids[QIDX_W'(q_head + q_count)] = id;
    q_count = q_count + 1'b1;
    return 1'b1;
  endfunction

  function automatic void try_switch(inout sched_report_t r);
    logic [ID_W-1:0] nxt;
    if (sw_locks != 0) begin
      sw_pending = 1'b1;
      r.deferred = 1'b1;
      return;
    end
    if (q_count == 0)
      return;
    nxt = ready_ids[q_head];
    q_head = q_head + 1'b1;
    q_count = q_count - 1'b1;
    // the head leaves first, so re-queueing the running task never overflows
    if (cur_running)
      void'(push_ready(cur_id));
    r.switched = 1'b1;
    r.from_task = cur_id;
    cur_id = nxt;
    cur_running = 1'b1;
    ticks_left = slice_cfg;
  endfunction

  function automatic sched_report_t apply_sched_event(input mode_t ev,
                                                      input logic [ID_W-1:0] id);
    sched_report_t r;
    r = '0;
    case (ev)
      MODE_TICK: begin
        if (ticks_left != 0)
          ticks_left = ticks_left - 1'b1;
        if (sched_holds == 0 && ticks_left == 0)
          try_switch(r);
      end
      MODE_BLOCK: begin
        cur_running = 1'b0;
        try_switch(r);
      end
      MODE_UNBLOCK: begin
        if (push_ready(id)) begin
          if (id == cur_id)
            cur_running = 1'b0;
        end else begin
          r.overflow = 1'b1;
        end
      end
      MODE_SCHED_LK: begin
        if (sched_holds != LOCK_TOP)
          sched_holds = sched_holds + 1'b1;
      end
      MODE_SCHED_UNL: begin
        if (sched_holds != 0)
          sched_holds = sched_holds - 1'b1;
      end
      MODE_SW_LK: begin
        if (sw_locks != LOCK_TOP)
          sw_locks = sw_locks + 1'b1;
      end
      MODE_SW_UNL: begin
        if (sw_locks != 0) begin
          sw_locks = sw_locks - 1'b1;
          // last unlock replays a postponed yield
          if (sw_locks == 0 && sw_pending) begin
            sw_pending = 1'b0;
            try_switch(r);
          end
        end
      end
      default: try_switch(r);
    endcase
    r.to_task = cur_id;
    r.ready_count = q_count;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 2);
    if (r < 95)
      return $urandom_range(3, 8);
    return $urandom_range(9, 30);
  endfunction

  function automatic mode_t random_mode(input int w_unblock);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)
      return MODE_TICK;
    if (r < 30 + w_unblock)
      return MODE_UNBLOCK;
    case ($urandom_range(0, 9))
      0, 1, 2: return MODE_YIELD;
      3, 4:    return MODE_BLOCK;
      5:       return MODE_SCHED_LK;
      6:       return MODE_SCHED_UNL;
      7:       return MODE_SW_LK;
      8:       return MODE_SW_UNL;
      default: return mode_t'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    return ID_W'($urandom_range(0, MAX_TASKS - 1));
  endfunction

  task automatic report_mismatch(input string what, input sched_report_t want,
                                 input sched_report_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t: report %0d %s: expected sw=%0b from=%0d to=%0d def=%0b",
                " cnt=%0d ovf=%0b, got sw=%0b from=%0d to=%0d def=%0b cnt=%0d",
                " ovf=%0b"},
               $realtime, reports_seen, what,
               want.switched, want.from_task, want.to_task, want.deferred,
               want.ready_count, want.overflow,
               seen.switched, seen.from_task, seen.to_task, seen.deferred,
               seen.ready_count, seen.overflow);
  endtask

  // result side: random stalls, none while steady
  always @(posedge clk) begin
    if (steady) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin : check_reports
    sched_report_t seen;
    sched_report_t want;
    if (!rst && out_ready && out_valid !== 1'b0) begin
      seen = {switched, from_task, to_task, deferred, ready_count, overflow};
      if (sched_reports.size() == 0) begin
        report_mismatch("with no item pending", '0, seen);
      end else begin
        want = sched_reports.pop_front();
        if (seen.switched !== want.switched || seen.from_task !== want.from_task ||
            seen.to_task !== want.to_task || seen.deferred !== want.deferred ||
            seen.ready_count !== want.ready_count || seen.overflow !== want.overflow)
          report_mismatch("differs", want, seen);
      end
      reports_seen++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("round_robin_task_scheduler: mismatch");
    $finish;
  end

  task automatic send_event(input mode_t ev, input logic [ID_W-1:0] id);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= ev;
    task_id  <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sched_reports.push_back(apply_sched_event(ev, id));
  endtask

  task automatic wait_idle();
    if (in_valid)
      in_valid <= 1'b0;
    while (sched_reports.size() != 0) @(posedge clk);
  endtask

  // write the slice register, then read it back in the same transfer run
  task automatic program_slice(input logic [SLICE_W-1:0] value);
    wait_idle();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLICE_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    slice_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(value)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: slice read back %0h, expected %0h", $realtime, prdata, value);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed();
    send_event(MODE_TICK, 4'hF);       // first unlocked tick yields on an empty queue
    send_event(MODE_UNBLOCK, 4'hF);
    send_event(MODE_UNBLOCK, 4'h0);    // unblock of the current task
    send_event(MODE_YIELD, 4'h0);
    send_event(MODE_BLOCK, 4'hA);
    send_event(MODE_BLOCK, 4'h5);      // block with nothing ready
    send_event(MODE_YIELD, 4'hF);
    send_event(MODE_UNBLOCK, 4'h5);
    send_event(MODE_UNBLOCK, 4'h5);    // duplicate id queued twice
    send_event(MODE_YIELD, 4'h0);
    send_event(MODE_SW_LK, 4'hF);
    send_event(MODE_YIELD, 4'h0);
    send_event(MODE_YIELD, 4'hF);      // deferred again while still pending
    send_event(MODE_UNBLOCK, 4'h3);
    send_event(MODE_SW_UNL, 4'h0);     // replay on last unlock
    send_event(MODE_SW_UNL, 4'hF);     // unlock at zero
    send_event(MODE_SCHED_LK, 4'h0);
    send_event(MODE_TICK, 4'h0);
    send_event(MODE_SCHED_UNL, 4'hF);
    send_event(MODE_SCHED_UNL, 4'h0);
    send_event(MODE_TICK, 4'h6);
    send_event(MODE_TICK, 4'h9);
  endtask

  task automatic test_slice_extremes();
    logic [SLICE_W-1:0] settings [4];
    int k;
    settings = '{16'h0000, 16'h0001, 16'hFFFF, 16'h000A};
    for (k = 0; k < 4; k++) begin
      program_slice(settings[k]);
      send_event(MODE_UNBLOCK, random_id());
      send_event(MODE_UNBLOCK, random_id());
      send_event(MODE_YIELD, random_id());
      send_event(MODE_TICK, random_id());
      send_event(MODE_TICK, random_id());
      send_event(MODE_TICK, random_id());
      send_event(MODE_BLOCK, random_id());
      send_event(MODE_YIELD, random_id());
    end
  endtask

  task automatic test_queue_overflow();
    int k;
    for (k = 0; k < 20; k++)
      send_event(MODE_UNBLOCK, random_id());
    send_event(MODE_YIELD, random_id());  // full queue, running task re-queued
    send_event(MODE_BLOCK, random_id());
    for (k = 0; k < 3; k++)
      send_event(MODE_UNBLOCK, random_id());
    for (k = 0; k < 5; k++)
      send_event(MODE_YIELD, random_id());
    for (k = 0; k < 18; k++)
      send_event(MODE_BLOCK, random_id());
  endtask

  task automatic test_lock_saturation();
    int k;
    steady = 1'b1;
    for (k = 0; k < 260; k++)
      send_event(MODE_SCHED_LK, random_id());
    steady = 1'b0;
    for (k = 0; k < 3; k++)
      send_event(MODE_TICK, random_id());
    send_event(MODE_UNBLOCK, random_id());
    for (k = 0; k < 255; k++)
      send_event(MODE_SCHED_UNL, random_id());
    send_event(MODE_SCHED_UNL, random_id());
    for (k = 0; k < 4; k++)
      send_event(MODE_TICK, random_id());

    for (k = 0; k < 260; k++)
      send_event(MODE_SW_LK, random_id());
    steady = 1'b1;
    send_event(MODE_YIELD, random_id());
    send_event(MODE_BLOCK, random_id());
    for (k = 0; k < 254; k++)
      send_event(MODE_SW_UNL, random_id());
    steady = 1'b0;
    send_event(MODE_UNBLOCK, random_id());
    send_event(MODE_SW_UNL, random_id());
    send_event(MODE_SW_UNL, random_id());
  endtask

  task automatic test_random_mix();
    int phase;
    int n;
    int w_unblock;
    logic [SLICE_W-1:0] s;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       s = 16'h0001;
        1:       s = SLICE_W'($urandom_range(2, 6));
        2:       s = 16'hFFFF;
        3:       s = SLICE_W'($urandom_range(1, 40));
        4:       s = 16'h0003;
        default: s = SLICE_W'($urandom_range(1, 12));
      endcase
      program_slice(s);
      steady = (phase == 4);
      w_unblock = $urandom_range(10, 30);
      for (n = 0; n < 110; n++)
        send_event(random_mode(w_unblock), random_id());
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_slice_extremes();
    test_queue_overflow();
    test_lock_saturation();
    test_random_mix();
    wait_idle();
    repeat (4) @(posedge clk);
    if (sched_reports.size() != 0)
      mismatches++;
    if (mismatches == 0)
      $display("round_robin_task_scheduler: match");
    else
      $display("round_robin_task_scheduler: mismatch");
    $finish;
  end

endmodule

// ===== round_robin_task_scheduler.f =====
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_cell.sv
hw/rtl/rrts_regs.sv
hw/rtl/round_robin_task_scheduler.sv
tb/sv/round_robin_task_scheduler_test.sv
